FILE: sv/nerd_pkg.sv
// ----------------------------------------------------------------------------
// nerd_pkg: shared types and constants
// Word formats, register indexes and fixed constants for the notch-filter
// energy-ratio tone detector.
// ----------------------------------------------------------------------------
package nerd_pkg;

    // Input word: one line sample, or a restart request
    typedef struct packed {
        logic signed [15:0] sample;
        logic               restart;
    } in_word_t;

    // Output word: detection flag and qualifying-block count
    typedef struct packed {
        logic       detected;
        logic [7:0] hit_count;
    } out_word_t;

    // Configuration port widths
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 31;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_B1_COEF    = 3'd0,
        REG_A1_COEF    = 3'd1,
        REG_A2_COEF    = 3'd2,
        REG_RATIO_SHFT = 3'd3,
        REG_IN_MIN     = 3'd4,
        REG_OUT_MAX    = 3'd5
    } cfg_index_t;

    // Register reset values
    localparam logic signed [15:0] B1_RESET        = 16'sd23170;
    localparam logic signed [15:0] A1_RESET        = 16'sd22012;
    localparam logic signed [15:0] A2_RESET        = 16'sd14787;
    localparam logic [3:0]         RATIO_RESET     = 4'd3;
    localparam logic [30:0]        IN_MIN_RESET    = 31'd150000;
    localparam logic [30:0]        OUT_MAX_RESET   = 31'd2250000;

    // Arithmetic constants
    localparam logic [31:0] Q14_HALF     = 32'h0000_2000;
    localparam logic [31:0] ENERGY_HALF  = 32'd32;
    localparam logic [7:0]  HIT_THRESH   = 8'd5;
    localparam logic [7:0]  HIT_MAX      = 8'd255;

endpackage

FILE: sv/notch_energy_retrain_detector_top.sv
// ----------------------------------------------------------------------------
// notch_energy_retrain_detector_top: notch-filter tone detector
// Q14 biquad notch on each sample, block energy sums of input and output,
// and a count of consecutive blocks whose energy ratio and bounds mark a tone.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake            | word
//  ---------+-----------+----------------------+-----------------------------
//  in       | input     | in_valid / in_stall  | in_data  (sample, restart)
//  out      | output    | out_valid / out_stall| out_data (detected, hit_count)
//  cfg      | input     | cfg_wr_en            | cfg_index, cfg_data
//
//  A sample word runs the filter products, the squares, the energy sums
//  and, at a block's last sample, the block evaluation; the next word can
//  be taken in the cycle after its result is loaded. All five products go
//  one after another through the single registered multiplier. A restart
//  word is loaded directly. in_stall is high from the cycle after accept
//  until the result is loaded into the output register; a stalled output
//  holds the sequencer in its final state. Reset clears the filter history,
//  energies and counts and loads the registers with their default values.
//
module notch_energy_retrain_detector_top #(
    parameter int unsigned BLOCK_LEN = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  nerd_pkg::in_word_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output nerd_pkg::out_word_t                 out_data,
    input  logic                                cfg_wr_en,
    input  logic [nerd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [nerd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int unsigned POS_W = $clog2(BLOCK_LEN);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(BLOCK_LEN - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A1,
        ST_MUL_A2,
        ST_MUL_B1,
        ST_SQ_X,
        ST_SQ_Y,
        ST_ACC_OUT,
        ST_EVAL,
        ST_DONE
    } state_t;

    // Configuration registers
    logic signed [15:0] b1_reg, a1_reg, a2_reg;
    logic [3:0]         ratio_reg;
    logic [30:0]        in_min_reg, out_max_reg;

    // Sequencer and datapath registers
    state_t             state_reg, state_next;
    logic signed [15:0] x_reg, x_next;
    logic signed [15:0] y_reg, y_next;
    logic signed [15:0] prev_in_reg, prev_in_next;
    logic signed [15:0] prev2_in_reg, prev2_in_next;
    logic signed [15:0] prev_out_reg, prev_out_next;
    logic signed [15:0] prev2_out_reg, prev2_out_next;
    logic [30:0]        ein_reg, ein_next;
    logic [30:0]        eout_reg, eout_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [7:0]         hits_reg, hits_next;
    logic               out_valid_reg, out_valid_next;
    nerd_pkg::out_word_t out_data_reg, out_data_next;

    // Multiplier operands and derived product terms
    logic signed [15:0] mul_a, mul_b;
    logic signed [31:0] mul_prod;
    logic [31:0]        rnd_sum;
    logic [15:0]        rnd_term;
    logic [31:0]        nrg_sum;
    logic [30:0]        nrg_term;
    logic               blk_hit;

    nerd_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_prod)
    );

    // Q14 rounding: only the low 16 bits of the shifted value matter
    assign rnd_sum  = $unsigned(mul_prod) + nerd_pkg::Q14_HALF;
    assign rnd_term = rnd_sum[29:14];

    // Scaled energy (v*v + 32) >> 6 from a square
    assign nrg_sum  = $unsigned(mul_prod) + nerd_pkg::ENERGY_HALF;
    assign nrg_term = {5'd0, nrg_sum[31:6]};

    // Block qualification
    assign blk_hit = ((ein_reg >> ratio_reg) > eout_reg)
                  && (ein_reg > in_min_reg)
                  && (eout_reg < out_max_reg);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_reg      <= nerd_pkg::B1_RESET;
            a1_reg      <= nerd_pkg::A1_RESET;
            a2_reg      <= nerd_pkg::A2_RESET;
            ratio_reg   <= nerd_pkg::RATIO_RESET;
            in_min_reg  <= nerd_pkg::IN_MIN_RESET;
            out_max_reg <= nerd_pkg::OUT_MAX_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                nerd_pkg::REG_B1_COEF:    b1_reg      <= cfg_data[15:0];
                nerd_pkg::REG_A1_COEF:    a1_reg      <= cfg_data[15:0];
                nerd_pkg::REG_A2_COEF:    a2_reg      <= cfg_data[15:0];
                nerd_pkg::REG_RATIO_SHFT: ratio_reg   <= cfg_data[3:0];
                nerd_pkg::REG_IN_MIN:     in_min_reg  <= cfg_data;
                nerd_pkg::REG_OUT_MAX:    out_max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer next-state and datapath
    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        prev_in_next   = prev_in_reg;
        prev2_in_next  = prev2_in_reg;
        prev_out_next  = prev_out_reg;
        prev2_out_next = prev2_out_reg;
        ein_next       = ein_reg;
        eout_next      = eout_reg;
        pos_next       = pos_reg;
        hits_next      = hits_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mul_a          = '0;
        mul_b          = '0;

        // output word taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    x_next = in_data.sample;
                    y_next = in_data.sample + prev2_in_reg;
                    if (in_data.restart)
                    begin
                        prev_in_next   = '0;
                        prev2_in_next  = '0;
                        prev_out_next  = '0;
                        prev2_out_next = '0;
                        ein_next       = '0;
                        eout_next      = '0;
                        pos_next       = '0;
                        hits_next      = '0;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_MUL_A1;
                    end
                end
            end
            ST_MUL_A1:
            begin
                mul_a      = prev_out_reg;
                mul_b      = a1_reg;
                state_next = ST_MUL_A2;
            end
            ST_MUL_A2:
            begin
                mul_a      = prev2_out_reg;
                mul_b      = a2_reg;
                y_next     = y_reg + $signed(rnd_term);
                state_next = ST_MUL_B1;
            end
            ST_MUL_B1:
            begin
                mul_a      = prev_in_reg;
                mul_b      = b1_reg;
                y_next     = y_reg - $signed(rnd_term);
                state_next = ST_SQ_X;
            end
            ST_SQ_X:
            begin
                mul_a      = x_reg;
                mul_b      = x_reg;
                y_next     = y_reg - $signed(rnd_term);
                state_next = ST_SQ_Y;
            end
            ST_SQ_Y:
            begin
                // y_reg holds the finished filter output here
                mul_a      = y_reg;
                mul_b      = y_reg;
                ein_next   = ein_reg + nrg_term;
                state_next = ST_ACC_OUT;
            end
            ST_ACC_OUT:
            begin
                eout_next      = eout_reg + nrg_term;
                prev2_in_next  = prev_in_reg;
                prev_in_next   = x_reg;
                prev2_out_next = prev_out_reg;
                prev_out_next  = y_reg;
                if (pos_reg == POS_LAST)
                begin
                    state_next = ST_EVAL;
                end
                else
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_EVAL:
            begin
                if (blk_hit)
                begin
                    if (hits_reg != nerd_pkg::HIT_MAX)
                    begin
                        hits_next = hits_reg + 8'd1;
                    end
                end
                else
                begin
                    hits_next = '0;
                end
                ein_next   = '0;
                eout_next  = '0;
                pos_next   = '0;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next.detected  = (hits_reg > nerd_pkg::HIT_THRESH);
                    out_data_next.hit_count = hits_reg;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prev_in_reg   <= '0;
            prev2_in_reg  <= '0;
            prev_out_reg  <= '0;
            prev2_out_reg <= '0;
            ein_reg       <= '0;
            eout_reg      <= '0;
            pos_reg       <= '0;
            hits_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_in_reg   <= prev_in_next;
            prev2_in_reg  <= prev2_in_next;
            prev_out_reg  <= prev_out_next;
            prev2_out_reg <= prev2_out_next;
            ein_reg       <= ein_next;
            eout_reg      <= eout_next;
            pos_reg       <= pos_next;
            hits_reg      <= hits_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working values and output word need no reset
    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        out_data_reg <= out_data_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: sv/nerd_mul.sv
// ----------------------------------------------------------------------------
// nerd_mul: shared signed multiplier
// One 16x16 signed multiply per cycle with a registered 32-bit product.
// ----------------------------------------------------------------------------
module nerd_mul (
    input  logic               clk,
    input  logic signed [15:0] op_a,
    input  logic signed [15:0] op_b,
    output logic signed [31:0] prod
);

    logic signed [31:0] prod_reg;

    // Product register; the sequencer only reads it in the cycle after issue
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

FILE: sv/nerd_chk.sv
// ----------------------------------------------------------------------------
// nerd_chk: port-level checks for the tone detector
// Watches the top-level ports over time; attached by bind.
// ----------------------------------------------------------------------------
module nerd_chk (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  nerd_pkg::in_word_t              in_data,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  nerd_pkg::out_word_t             out_data
);

    // A stalled output word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output word changed under stall");

    // Flag agrees with the count it is derived from
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.detected == (out_data.hit_count > nerd_pkg::HIT_THRESH)))
        else $error("detected flag disagrees with hit count");

    // One word at a time: an accept is followed by a busy cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second word accepted while busy");

    // A restart word reports a cleared count
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.restart && (!out_valid || !out_stall)
        |=> ##1 out_valid && (out_data.hit_count == 8'd0) && !out_data.detected)
        else $error("restart did not clear the count");

endmodule

bind notch_energy_retrain_detector_top nerd_chk u_nerd_chk (.*);
